### sv/smdn_pkg.sv
package smdn_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WL_W        = 13;
    localparam int SC_W        = 6;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int VAL_W       = 16;
    localparam int SIDX_W      = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_MAX_SEGMENTS = 32;
    localparam int DEF_MAX_WINDOW   = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'b1;

    localparam logic [WL_W-1:0] RST_WINDOW_LENGTH = 13'd128;
    localparam logic [SC_W-1:0] RST_SEGMENT_COUNT = 6'd8;

    localparam logic [VAL_W-1:0] SCALE_Q8 = 16'd65280;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

    typedef struct packed {
        logic                       seg_done;
        logic                       win_done;
        logic signed [SAMPLE_W-1:0] seg_max;
    } smdn_rec_t;

endpackage

### sv/smdn_front.sv
module smdn_front #(
    parameter int MAX_SEGMENTS = smdn_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_WINDOW   = smdn_pkg::DEF_MAX_WINDOW
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     wr_en,
    input  logic [smdn_pkg::CFG_IDX_W-1:0]           wr_index,
    input  logic [smdn_pkg::CFG_W-1:0]               wr_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [smdn_pkg::SAMPLE_W-1:0]     sample,
    output logic                                     restart,
    output logic                                     rec_push,
    output smdn_pkg::smdn_rec_t                      rec_data,
    input  logic                                     rec_full
);
    import smdn_pkg::*;

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DCNT_W = $clog2(WIN_W + 1);

    logic [WL_W-1:0]             wl_reg;
    logic [SC_W-1:0]             sc_reg;
    logic                        start_reg;
    logic [WIN_W-1:0]            div_q_reg;
    logic [SEG_W-1:0]            div_r_reg;
    logic [DCNT_W-1:0]           div_cnt_reg;
    logic [WIN_W-1:0]            win_cnt_reg;
    logic [WIN_W-1:0]            seg_cnt_reg;
    logic [SEG_W-1:0]            cur_seg_reg;
    logic signed [SAMPLE_W-1:0]  run_max_reg;

    logic                        wl_we;
    logic                        sc_we;
    logic [WIN_W-1:0]            eff_w;
    logic [SEG_W-1:0]            seg_lim;
    logic [SEG_W-1:0]            eff_s;
    logic [SEG_W:0]              div_t;
    logic                        div_ge;
    logic [SEG_W-1:0]            div_r_next;
    logic                        div_busy;
    logic                        in_acc;
    logic                        seg_act;
    logic                        seg_end;
    logic                        win_end;
    logic signed [SAMPLE_W-1:0]  new_max;

    always_comb
    begin
        wl_we = 1'b0;
        sc_we = 1'b0;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_WINDOW_LENGTH: wl_we = 1'b1;
                REG_SEGMENT_COUNT: sc_we = 1'b1;
                default: ;
            endcase
        end
    end

    assign restart = wl_we | sc_we;

    always_comb
    begin
        if (wl_reg == '0)
            eff_w = WIN_W'(1);
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
            eff_w = WIN_W'(MAX_WINDOW);
        else
            eff_w = WIN_W'(wl_reg);

        if (sc_reg == '0)
            seg_lim = SEG_W'(1);
        else if (32'(sc_reg) > 32'(MAX_SEGMENTS))
            seg_lim = SEG_W'(MAX_SEGMENTS);
        else
            seg_lim = SEG_W'(sc_reg);

        if (32'(seg_lim) > 32'(eff_w))
            eff_s = SEG_W'(eff_w);
        else
            eff_s = seg_lim;
    end

    always_comb
    begin
        div_t      = {div_r_reg, div_q_reg[WIN_W-1]};
        div_ge     = (div_t >= {1'b0, eff_s});
        div_r_next = div_ge ? SEG_W'(div_t - {1'b0, eff_s}) : SEG_W'(div_t);
    end

    assign div_busy = start_reg || (div_cnt_reg != '0);
    assign in_stall = div_busy || rec_full;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        seg_act  = (cur_seg_reg < eff_s);
        new_max  = (sample > run_max_reg) ? sample : run_max_reg;
        seg_end  = seg_act && (WIN_W'(seg_cnt_reg + 1'b1) == div_q_reg);
        win_end  = (WIN_W'(win_cnt_reg + 1'b1) == eff_w);
        rec_push = in_acc && (seg_end || win_end);
        rec_data.seg_done = seg_end;
        rec_data.win_done = win_end;
        rec_data.seg_max  = new_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg      <= RST_WINDOW_LENGTH;
            sc_reg      <= RST_SEGMENT_COUNT;
            start_reg   <= 1'b1;
            div_q_reg   <= '0;
            div_r_reg   <= '0;
            div_cnt_reg <= '0;
            win_cnt_reg <= '0;
            seg_cnt_reg <= '0;
            cur_seg_reg <= '0;
            run_max_reg <= SAMPLE_MIN;
        end
        else
        begin
            if (wl_we)
                wl_reg <= wr_data[WL_W-1:0];
            if (sc_we)
                sc_reg <= wr_data[SC_W-1:0];

            start_reg <= restart;

            if (start_reg)
            begin
                div_q_reg   <= eff_w;
                div_r_reg   <= '0;
                div_cnt_reg <= DCNT_W'(WIN_W);
            end
            else if (div_cnt_reg != '0)
            begin
                div_q_reg   <= {div_q_reg[WIN_W-2:0], div_ge};
                div_r_reg   <= div_r_next;
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            if (restart)
            begin
                win_cnt_reg <= '0;
                seg_cnt_reg <= '0;
                cur_seg_reg <= '0;
                run_max_reg <= SAMPLE_MIN;
            end
            else if (in_acc)
            begin
                if (win_end)
                begin
                    win_cnt_reg <= '0;
                    seg_cnt_reg <= '0;
                    cur_seg_reg <= '0;
                    run_max_reg <= SAMPLE_MIN;
                end
                else
                begin
                    win_cnt_reg <= win_cnt_reg + 1'b1;
                    if (seg_act)
                    begin
                        if (seg_end)
                        begin
                            cur_seg_reg <= cur_seg_reg + 1'b1;
                            seg_cnt_reg <= '0;
                            run_max_reg <= SAMPLE_MIN;
                        end
                        else
                        begin
                            seg_cnt_reg <= seg_cnt_reg + 1'b1;
                            run_max_reg <= new_max;
                        end
                    end
                end
            end
        end
    end

endmodule

### sv/smdn_queue.sv
module smdn_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  smdn_pkg::smdn_rec_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output smdn_pkg::smdn_rec_t  pop_data,
    output logic                 empty
);
    import smdn_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    smdn_rec_t          slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/smdn_back.sv
module smdn_back #(
    parameter int MAX_SEGMENTS = smdn_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  logic                              rec_empty,
    input  smdn_pkg::smdn_rec_t               rec_data,
    output logic                              rec_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [smdn_pkg::VAL_W-1:0]        normalized_value,
    output logic [smdn_pkg::SIDX_W-1:0]       segment_index,
    output logic                              last_segment
);
    import smdn_pkg::*;

    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int STEP_W = $clog2(VAL_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_PUT  = 3'd5;

    logic signed [SAMPLE_W-1:0]  mem [MAX_SEGMENTS];
    logic signed [SAMPLE_W-1:0]  rd_data_reg;

    logic [2:0]                  state_reg;
    logic [SEG_W-1:0]            wr_cnt_reg;
    logic [SEG_W-1:0]            em_idx_reg;
    logic signed [SAMPLE_W-1:0]  mn_reg;
    logic signed [SAMPLE_W-1:0]  mx_reg;
    logic [VAL_W-1:0]            delta_reg;
    logic [VAL_W-1:0]            dq_reg;
    logic [VAL_W-1:0]            dr_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        out_valid_reg;
    logic [VAL_W-1:0]            out_val_reg;
    logic [SIDX_W-1:0]           out_idx_reg;
    logic                        out_last_reg;

    logic [VAL_W-1:0]            diff;
    logic [2*VAL_W-1:0]          prod;
    logic [VAL_W:0]              div_t;
    logic                        div_ge;
    logic [VAL_W-1:0]            dr_next;
    logic                        is_last;
    logic                        out_free;

    assign rec_pop = (state_reg == ST_IDLE) && !rec_empty;

    always_comb
    begin
        diff     = VAL_W'(rd_data_reg - mn_reg);
        prod     = (2*VAL_W)'(diff) * (2*VAL_W)'(SCALE_Q8);
        div_t    = {dr_reg, dq_reg[VAL_W-1]};
        div_ge   = (div_t >= {1'b0, delta_reg});
        dr_next  = div_ge ? VAL_W'(div_t - {1'b0, delta_reg}) : VAL_W'(div_t);
        is_last  = (SEG_W'(em_idx_reg + 1'b1) == wr_cnt_reg);
        out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop && rec_data.seg_done)
            mem[wr_cnt_reg[IDX_W-1:0]] <= rec_data.seg_max;
        if (state_reg == ST_READ)
            rd_data_reg <= mem[em_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_cnt_reg    <= '0;
            em_idx_reg    <= '0;
            mn_reg        <= SAMPLE_MAX;
            mx_reg        <= SAMPLE_MIN;
            delta_reg     <= '0;
            dq_reg        <= '0;
            dr_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_PUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (restart)
                    begin
                        wr_cnt_reg <= '0;
                        mn_reg     <= SAMPLE_MAX;
                        mx_reg     <= SAMPLE_MIN;
                    end
                    else if (rec_pop)
                    begin
                        if (rec_data.seg_done)
                        begin
                            wr_cnt_reg <= wr_cnt_reg + 1'b1;
                            if (rec_data.seg_max < mn_reg)
                                mn_reg <= rec_data.seg_max;
                            if (rec_data.seg_max > mx_reg)
                                mx_reg <= rec_data.seg_max;
                        end
                        if (rec_data.win_done)
                            state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    delta_reg  <= VAL_W'(mx_reg - mn_reg);
                    em_idx_reg <= '0;
                    state_reg  <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    dr_reg    <= prod[2*VAL_W-1:VAL_W];
                    dq_reg    <= prod[VAL_W-1:0];
                    step_reg  <= STEP_W'(VAL_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dr_reg   <= dr_next;
                    dq_reg   <= {dq_reg[VAL_W-2:0], div_ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                        state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= (delta_reg == '0) ? '0 : dq_reg;
                        out_idx_reg   <= SIDX_W'(em_idx_reg);
                        out_last_reg  <= is_last;
                        if (is_last)
                        begin
                            wr_cnt_reg <= '0;
                            mn_reg     <= SAMPLE_MAX;
                            mx_reg     <= SAMPLE_MIN;
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            em_idx_reg <= em_idx_reg + 1'b1;
                            state_reg  <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign normalized_value = out_val_reg;
    assign segment_index    = out_idx_reg;
    assign last_segment     = out_last_reg;

endmodule

### sv/segment_max_downsample_normalize.sv
// Segment max downsampling with min-max normalization. Samples enter one per cycle while
// in_stall is low into a front end that tracks each segment's maximum and hands finished
// segment maxima through a four-entry queue to a back end. After the last sample of a window
// the back end emits one result per segment, each through a memory read, one multiply, a
// 16-step divider and the output register, in segment order; the front end keeps taking the
// next window's samples until the queue fills. Reset and every configuration write start a
// per-segment length divide during which input is stalled, and restart the current window.
// The normalized value is unsigned Q8.8, 0 when all segment maxima match.
module segment_max_downsample_normalize #(
    parameter int MAX_SEGMENTS = smdn_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_WINDOW   = smdn_pkg::DEF_MAX_WINDOW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [smdn_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [smdn_pkg::CFG_W-1:0]            wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [smdn_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [smdn_pkg::VAL_W-1:0]            normalized_value,
    output logic [smdn_pkg::SIDX_W-1:0]           segment_index,
    output logic                                  last_segment
);
    import smdn_pkg::*;

    logic       restart;
    logic       rec_push;
    logic       rec_full;
    logic       rec_pop;
    logic       rec_empty;
    smdn_rec_t  push_rec;
    smdn_rec_t  pop_rec;

    smdn_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .restart  (restart),
        .rec_push (rec_push),
        .rec_data (push_rec),
        .rec_full (rec_full)
    );

    smdn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (rec_full),
        .pop       (rec_pop),
        .pop_data  (pop_rec),
        .empty     (rec_empty)
    );

    smdn_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .restart          (restart),
        .rec_empty        (rec_empty),
        .rec_data         (pop_rec),
        .rec_pop          (rec_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .normalized_value (normalized_value),
        .segment_index    (segment_index),
        .last_segment     (last_segment)
    );

endmodule

### bench/tb_segment_max_downsample_normalize.sv
`timescale 1ns / 100ps

module tb_segment_max_downsample_normalize;

    import smdn_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 1500;
    localparam int RANDOM_ITEMS = 110;

    typedef enum int {
        MODE_FULL,
        MODE_EXTREME,
        MODE_NARROW,
        MODE_FLAT
    } fill_mode_t;

    typedef struct {
        logic [VAL_W-1:0]  level;
        logic [SIDX_W-1:0] seg;
        logic              last;
    } norm_level_t;

    class segment_norm_tracker;
        logic [WL_W-1:0]            win_len_reg;
        logic [SC_W-1:0]            seg_cnt_reg;
        logic signed [SAMPLE_W-1:0] seg_peak [DEF_MAX_SEGMENTS];
        logic signed [SAMPLE_W-1:0] peak_now;
        int unsigned                samples_in_win;
        int unsigned                samples_in_seg;
        int unsigned                seg_pos;
        norm_level_t                due_levels [$];
        int unsigned                errors;

        function new();
            win_len_reg = RST_WINDOW_LENGTH;
            seg_cnt_reg = RST_SEGMENT_COUNT;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            samples_in_win = 0;
            samples_in_seg = 0;
            seg_pos        = 0;
            peak_now       = SAMPLE_MIN;
        endfunction

        function int unsigned window_size();
            int unsigned w;
            w = win_len_reg;
            if (w < 1) w = 1;
            if (w > DEF_MAX_WINDOW) w = DEF_MAX_WINDOW;
            return w;
        endfunction

        function int unsigned segment_total();
            int unsigned s;
            s = seg_cnt_reg;
            if (s < 1) s = 1;
            if (s > DEF_MAX_SEGMENTS) s = DEF_MAX_SEGMENTS;
            if (s > window_size()) s = window_size();
            return s;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WINDOW_LENGTH)
                win_len_reg = data[WL_W-1:0];
            else
                seg_cnt_reg = data[SC_W-1:0];
            restart();
        endfunction

        function int unsigned pending();
            return due_levels.size();
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] x);
            int unsigned w;
            int unsigned s;
            int          lo;
            int          hi;
            int          v;
            logic [63:0] q;
            norm_level_t lvl;
            w = window_size();
            s = segment_total();
            if (seg_pos < s) begin
                if (x > peak_now) peak_now = x;
                samples_in_seg++;
                if (samples_in_seg >= w / s) begin
                    seg_peak[seg_pos] = peak_now;
                    seg_pos++;
                    samples_in_seg = 0;
                    peak_now = SAMPLE_MIN;
                end
            end
            samples_in_win++;
            if (samples_in_win < w) return;
            lo = 32767;
            hi = -32768;
            for (int i = 0; i < s; i++) begin
                v = seg_peak[i];
                if (v < lo) lo = v;
                if (v > hi) hi = v;
            end
            for (int i = 0; i < s; i++) begin
                v = seg_peak[i];
                if (hi == lo)
                    q = 64'd0;
                else
                    q = (64'(v - lo) * 64'(SCALE_Q8)) / 64'(hi - lo);
                lvl.level = q[VAL_W-1:0];
                lvl.seg   = SIDX_W'(i);
                lvl.last  = (i + 1 == s);
                due_levels.push_back(lvl);
            end
            restart();
        endfunction

        function void match_level(logic [VAL_W-1:0] level, logic [SIDX_W-1:0] seg,
                                  logic last);
            norm_level_t want;
            if (due_levels.size() == 0) begin
                $error("unexpected result: normalized_value %0d, segment_index %0d",
                       level, seg);
                errors++;
                return;
            end
            want = due_levels.pop_front();
            if (level !== want.level) begin
                $error("normalized_value: expected %0d, got %0d", want.level, level);
                errors++;
            end
            if (seg !== want.seg) begin
                $error("segment_index: expected %0d, got %0d", want.seg, seg);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_segment: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       wr_index = REG_WINDOW_LENGTH;
    logic [CFG_W-1:0]           wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [VAL_W-1:0]           normalized_value;
    logic [SIDX_W-1:0]          segment_index;
    logic                       last_segment;

    bit                  no_idle = 1'b0;
    bit                  hold_pending = 1'b0;
    int unsigned         random_sent = 0;
    segment_norm_tracker sb;

    segment_max_downsample_normalize i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .normalized_value (normalized_value),
        .segment_index    (segment_index),
        .last_segment     (last_segment)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < 37);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.match_level(normalized_value, segment_index, last_segment);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_mode_t mode,
                                                               logic signed [SAMPLE_W-1:0] base);
        logic signed [SAMPLE_W-1:0] x;
        x = SAMPLE_W'($urandom_range(0, 65535));
        case (mode)
            MODE_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0: x = SAMPLE_MIN;
                    1: x = SAMPLE_MAX;
                    2: x = '0;
                    3: x = '1;
                    default: ;
                endcase
            end
            MODE_NARROW: x = base + SAMPLE_W'($urandom_range(0, 3));
            MODE_FLAT:   x = base;
            default: ;
        endcase
        return x;
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
        bit took;
        if (!no_idle && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        sb.take_sample(v);
    endtask

    // drop valid, wait out pending results and any partial-window work
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit do_wl, input logic [CFG_W-1:0] wl_data,
                             input bit do_sc, input logic [CFG_W-1:0] sc_data);
        settle();
        if (do_wl)
        begin
            wr_en    <= 1'b1;
            wr_index <= REG_WINDOW_LENGTH;
            wr_data  <= wl_data;
            @(posedge clk);
            sb.write_reg(REG_WINDOW_LENGTH, wl_data);
        end
        if (do_sc)
        begin
            wr_en    <= 1'b1;
            wr_index <= REG_SEGMENT_COUNT;
            wr_data  <= sc_data;
            @(posedge clk);
            sb.write_reg(REG_SEGMENT_COUNT, sc_data);
        end
        wr_en <= 1'b0;
    endtask

    task automatic run_phase();
        logic [CFG_W-1:0]           wl_data;
        logic [CFG_W-1:0]           sc_data;
        logic signed [SAMPLE_W-1:0] base;
        int unsigned                w;
        int unsigned                total;
        int unsigned                r;
        fill_mode_t                 mode;
        r = $urandom_range(0, 99);
        wl_data = (r < 8) ? '0 : CFG_W'($urandom_range(1, 40));
        sc_data = CFG_W'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0)
            sc_data = sc_data | (CFG_W'($urandom_range(0, 127)) << SC_W);
        r = $urandom_range(0, 99);
        if (r < 60)
            configure(1'b1, wl_data, 1'b1, sc_data);
        else if (r < 80)
            configure(1'b1, wl_data, 1'b0, '0);
        else
            configure(1'b0, '0, 1'b1, sc_data);
        w = sb.window_size();
        r = $urandom_range(0, 99);
        if (r < 10)
            total = $urandom_range(1, 5);
        else
        begin
            total = w * $urandom_range(1, 3);
            if (r < 25 && w > 1)
                total += $urandom_range(1, w - 1);
        end
        if (total > RANDOM_ITEMS - random_sent)
            total = RANDOM_ITEMS - random_sent;
        r = $urandom_range(0, 99);
        if (r < 45)
            mode = MODE_FULL;
        else if (r < 65)
            mode = MODE_EXTREME;
        else if (r < 90)
            mode = MODE_NARROW;
        else
            mode = MODE_FLAT;
        base = SAMPLE_W'($urandom_range(0, 65535));
        no_idle = (random_sent >= 20 && random_sent < 80);
        repeat (total)
        begin
            push_sample(pick_sample(mode, base));
            random_sent++;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: 128 samples, 8 segments
        repeat (128) push_sample(pick_sample(MODE_FULL, '0));

        // zero lengths fall back to one sample, one segment
        configure(1'b1, '0, 1'b1, '0);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);

        // full sample range across four segments
        configure(1'b1, CFG_W'(4), 1'b1, CFG_W'(4));
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample('0);
        push_sample('1);

        // trailing sample outside the last segment
        configure(1'b1, CFG_W'(5), 1'b1, CFG_W'(2));
        push_sample(16'sd100);
        push_sample(-16'sd5);
        push_sample(16'sd7);
        push_sample(16'sd7);
        push_sample(SAMPLE_MAX);

        // segment count above the limit and above the window length
        configure(1'b1, CFG_W'(3), 1'b1, CFG_W'(40));
        push_sample(16'sd1);
        push_sample(16'sd2);
        push_sample(16'sd3);

        // flat window
        configure(1'b1, CFG_W'(2), 1'b1, CFG_W'(2));
        push_sample(-16'sd7);
        push_sample(-16'sd7);

        // write in mid-window restarts it
        configure(1'b1, CFG_W'(6), 1'b1, CFG_W'(2));
        push_sample(16'sd10);
        push_sample(16'sd20);
        push_sample(16'sd30);
        configure(1'b0, '0, 1'b1, CFG_W'(3));
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(-16'sd200);
        push_sample(16'sd300);
        push_sample(16'sd0);
        push_sample(-16'sd1);

        // largest window and segment count, both clamped; partial window only
        configure(1'b1, '1, 1'b1, CFG_W'(63));
        repeat (16) push_sample(pick_sample(MODE_FULL, '0));

        // hold the output long enough to back up the input
        configure(1'b1, CFG_W'(16), 1'b1, CFG_W'(8));
        hold_pending = 1'b1;
        repeat (64) push_sample(pick_sample(MODE_FULL, '0));

        while (random_sent < RANDOM_ITEMS) run_phase();
        no_idle = 1'b0;

        settle();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/smdn_pkg.sv
sv/smdn_front.sv
sv/smdn_queue.sv
sv/smdn_back.sv
sv/segment_max_downsample_normalize.sv
bench/tb_segment_max_downsample_normalize.sv
